@@ design/pba_pkg.sv @@
`default_nettype none

package pba_pkg;

  // Command codes
  localparam logic [1:0] CMD_BIND      = 2'd0;
  localparam logic [1:0] CMD_BIND_FREE = 2'd1;
  localparam logic [1:0] CMD_SHARE     = 2'd2;
  localparam logic [1:0] CMD_RELEASE   = 2'd3;

  // Status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_IN_USE    = 3'd1;
  localparam logic [2:0] STATUS_NO_FREE   = 3'd2;
  localparam logic [2:0] STATUS_NOT_BOUND = 3'd3;
  localparam logic [2:0] STATUS_LIMIT     = 3'd4;

  // Sharer count saturation point
  localparam logic [7:0] MAX_SHARERS = 8'd255;

  // Configuration register indexes and reset values
  localparam logic        CFG_RANGE_START = 1'b0;
  localparam logic        CFG_RANGE_END   = 1'b1;
  localparam logic [15:0] RANGE_START_RST = 16'd1025;
  localparam logic [15:0] RANGE_END_RST   = 16'd65535;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] port;
    logic [15:0] held_port;
    logic [15:0] last_used;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] bound_port;
  } out_item_t;

  // Search window: first port and last port (inclusive), 17 bit
  typedef struct packed {
    logic [16:0] lo;
    logic [16:0] last;
  } scan_win_t;

  // Outcome of checking one 32-port occupancy word
  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } scan_res_t;

endpackage

`default_nettype wire

@@ design/pba_word_scan.sv @@
`default_nettype none

// Finds the lowest free port of one 32-port occupancy word that lies inside
// the search window. Port zero is never free.
module pba_word_scan #(
  parameter int AW = 11
) (
  input  var logic [31:0]          word_i,
  input  var logic [AW-1:0]        word_idx_i,
  input  var pba_pkg::scan_win_t   win_i,
  output pba_pkg::scan_res_t       res_o
);

  logic [31:0] lo_mask;
  logic [31:0] hi_mask;
  logic [31:0] free_bits;

  // Window edges inside this word
  always_comb begin
    if (12'(word_idx_i) == win_i.lo[16:5]) begin
      lo_mask = 32'hFFFF_FFFF << win_i.lo[4:0];
    end else begin
      lo_mask = 32'hFFFF_FFFF;
    end
    if (12'(word_idx_i) == win_i.last[16:5]) begin
      hi_mask = 32'hFFFF_FFFF >> (5'd31 - win_i.last[4:0]);
    end else begin
      hi_mask = 32'hFFFF_FFFF;
    end
    free_bits = ~word_i & lo_mask & hi_mask;
    if (word_idx_i == '0) begin
      free_bits[0] = 1'b0;
    end
  end

  // Lowest set bit wins
  always_comb begin
    res_o.hit = 1'b0;
    res_o.idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (free_bits[i]) begin
        res_o.hit = 1'b1;
        res_o.idx = 5'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/port_binding_allocator.sv @@
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (pba_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i  out_data_o (pba_pkg::out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One command at a time. Release and share pass dispatch, a read of the occupancy
// and count memories and the result; bind to a given port checks the port, drops
// the held port, re-reads and claims. Free-port bind scans 32-port occupancy words
// in turn through the single read port of the occupancy memory.
// After reset a clearing pass writes zero to every word of the occupancy memory;
// no command is taken meanwhile, config writes are.
// A waiting result sits in the output register while the next command enters.
module port_binding_allocator #(
  parameter int NUM_PORTS = 65536
) (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               in_valid_i,
  output logic                   in_ready_o,
  input  var pba_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  var logic               out_ready_i,
  output pba_pkg::out_item_t     out_data_o,
  input  var logic               cfg_valid_i,
  output logic                   cfg_ready_o,
  input  var logic               cfg_index_i,
  input  var logic [15:0]        cfg_data_i
);

  localparam int NumWords = (NUM_PORTS + 31) / 32;
  localparam int AW = $clog2(NumWords);
  localparam int PW = AW + 5;
  localparam logic [16:0] NumPorts17 = 17'(NUM_PORTS);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_CHKP  = 4'd3;
  localparam logic [3:0] ST_CHKH  = 4'd4;
  localparam logic [3:0] ST_RDP2  = 4'd5;
  localparam logic [3:0] ST_CLAIM = 4'd6;
  localparam logic [3:0] ST_SETUP = 4'd7;
  localparam logic [3:0] ST_SCAN  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // Memories: one occupancy bit per port, one sharer count per port
  logic [31:0] occ_mem [NumWords];
  logic [7:0]  cnt_mem [NUM_PORTS];

  logic [3:0]            state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [15:0]           range_start_q, range_end_q;
  pba_pkg::in_item_t     item_q, item_d;
  logic [2:0]            res_status_q, res_status_d;
  logic [15:0]           res_port_q, res_port_d;
  logic                  out_valid_q, out_valid_d;
  pba_pkg::out_item_t    out_data_q, out_data_d;
  logic                  seg_sel_q, seg_sel_d;
  pba_pkg::scan_win_t    win_q, win_d;
  logic [AW:0]           iss_q, iss_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [AW-1:0]         rd_w_q, rd_w_d;

  logic                  occ_ren, occ_we;
  logic [AW-1:0]         occ_raddr, occ_waddr;
  logic [31:0]           occ_wdata, occ_rdata_q;
  logic                  cnt_ren, cnt_we;
  logic [PW-1:0]         cnt_raddr, cnt_waddr;
  logic [7:0]            cnt_wdata, cnt_rdata_q;

  logic                  port_in, held_in, port_bit, held_bit, issue, slot_free;
  logic [16:0]           seg_lo, seg_hi, seg_hi_eff;
  logic                  seg_empty;
  pba_pkg::scan_res_t    scan_res;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Occupancy memory
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_ren) begin
      occ_rdata_q <= occ_mem[occ_raddr];
    end
  end

  // Sharer count memory; an entry means something only while its bit is set
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_ren) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  // Port classification for the current command
  assign port_in  = (item_q.port != 16'd0) && ({1'b0, item_q.port} < NumPorts17);
  assign held_in  = (item_q.held_port != 16'd0) && ({1'b0, item_q.held_port} < NumPorts17);
  assign port_bit = occ_rdata_q[item_q.port[4:0]];
  assign held_bit = occ_rdata_q[item_q.held_port[4:0]];

  // Search segment bounds: after last_used, then the wrap-around part
  always_comb begin
    if (!seg_sel_q) begin
      seg_lo = {1'b0, item_q.last_used} + 17'd1;
      seg_hi = {1'b0, range_end_q};
    end else begin
      seg_lo = {1'b0, range_start_q};
      seg_hi = {1'b0, item_q.last_used};
    end
    seg_hi_eff = (seg_hi < NumPorts17) ? seg_hi : NumPorts17;
    seg_empty  = (seg_lo >= seg_hi_eff);
  end

  pba_word_scan #(
    .AW (AW)
  ) u_scan (
    .word_i     (occ_rdata_q),
    .word_idx_i (rd_w_q),
    .win_i      (win_q),
    .res_o      (scan_res)
  );

  assign issue     = (iss_q <= {1'b0, win_q.last[AW+4:5]});
  assign slot_free = !out_valid_q || out_ready_i;

  // Command sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_port_d   = res_port_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    seg_sel_d    = seg_sel_q;
    win_d        = win_q;
    iss_d        = iss_q;
    rd_vld_d     = 1'b0;
    rd_w_d       = iss_q[AW-1:0];
    occ_ren      = 1'b0;
    occ_raddr    = item_q.port[AW+4:5];
    occ_we       = 1'b0;
    occ_waddr    = item_q.port[AW+4:5];
    occ_wdata    = occ_rdata_q;
    cnt_ren      = 1'b0;
    cnt_raddr    = item_q.port[PW-1:0];
    cnt_we       = 1'b0;
    cnt_waddr    = item_q.port[PW-1:0];
    cnt_wdata    = 8'd1;

    unique case (state_q)
      ST_CLR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = 32'd0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NumWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (item_q.cmd)
          pba_pkg::CMD_BIND: begin
            if (item_q.port == 16'd0) begin
              seg_sel_d = 1'b0;
              state_d   = ST_SETUP;
            end else begin
              occ_ren = 1'b1;
              state_d = ST_CHKP;
            end
          end
          pba_pkg::CMD_BIND_FREE: begin
            seg_sel_d = 1'b0;
            state_d   = ST_SETUP;
          end
          pba_pkg::CMD_SHARE: begin
            occ_ren = 1'b1;
            cnt_ren = 1'b1;
            state_d = ST_CHKP;
          end
          pba_pkg::CMD_RELEASE: begin
            occ_ren   = 1'b1;
            occ_raddr = item_q.held_port[AW+4:5];
            cnt_ren   = 1'b1;
            cnt_raddr = item_q.held_port[PW-1:0];
            state_d   = ST_CHKH;
          end
        endcase
      end
      ST_CHKP: begin
        res_port_d = 16'd0;
        state_d    = ST_DONE;
        if (item_q.cmd == pba_pkg::CMD_SHARE) begin
          priority if (!port_in || !port_bit) begin
            res_status_d = pba_pkg::STATUS_NOT_BOUND;
          end else if (cnt_rdata_q >= pba_pkg::MAX_SHARERS) begin
            res_status_d = pba_pkg::STATUS_LIMIT;
          end else begin
            cnt_we       = 1'b1;
            cnt_wdata    = cnt_rdata_q + 8'd1;
            res_status_d = pba_pkg::STATUS_OK;
            res_port_d   = item_q.port;
          end
        end else if (!port_in || port_bit) begin
          res_status_d = pba_pkg::STATUS_IN_USE;
        end else begin
          // free: drop the caller's held port first
          occ_ren   = 1'b1;
          occ_raddr = item_q.held_port[AW+4:5];
          cnt_ren   = 1'b1;
          cnt_raddr = item_q.held_port[PW-1:0];
          state_d   = ST_CHKH;
        end
      end
      ST_CHKH: begin
        if (held_in && held_bit) begin
          cnt_we    = 1'b1;
          cnt_waddr = item_q.held_port[PW-1:0];
          cnt_wdata = cnt_rdata_q - 8'd1;
          if (cnt_rdata_q == 8'd1) begin
            occ_we    = 1'b1;
            occ_waddr = item_q.held_port[AW+4:5];
            occ_wdata = occ_rdata_q & ~(32'd1 << item_q.held_port[4:0]);
          end
        end
        if (item_q.cmd == pba_pkg::CMD_RELEASE) begin
          res_status_d = pba_pkg::STATUS_OK;
          res_port_d   = 16'd0;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_RDP2;
        end
      end
      ST_RDP2: begin
        // re-read after the release write, which may hit the same word
        occ_ren = 1'b1;
        state_d = ST_CLAIM;
      end
      ST_CLAIM: begin
        occ_we       = 1'b1;
        occ_wdata    = occ_rdata_q | (32'd1 << item_q.port[4:0]);
        cnt_we       = 1'b1;
        res_status_d = pba_pkg::STATUS_OK;
        res_port_d   = item_q.port;
        state_d      = ST_DONE;
      end
      ST_SETUP: begin
        if (seg_empty) begin
          if (!seg_sel_q) begin
            seg_sel_d = 1'b1;
          end else begin
            res_status_d = pba_pkg::STATUS_NO_FREE;
            res_port_d   = 16'd0;
            state_d      = ST_DONE;
          end
        end else begin
          win_d.lo   = seg_lo;
          win_d.last = seg_hi_eff - 17'd1;
          iss_d      = {1'b0, seg_lo[AW+4:5]};
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // streamed word reads, one check per returned word
        if (issue) begin
          occ_ren   = 1'b1;
          occ_raddr = iss_q[AW-1:0];
          iss_d     = iss_q + (AW+1)'(1);
          rd_vld_d  = 1'b1;
        end
        if (rd_vld_q) begin
          if (scan_res.hit) begin
            occ_we       = 1'b1;
            occ_waddr    = rd_w_q;
            occ_wdata    = occ_rdata_q | (32'd1 << scan_res.idx);
            cnt_we       = 1'b1;
            cnt_waddr    = {rd_w_q, scan_res.idx};
            res_status_d = pba_pkg::STATUS_OK;
            res_port_d   = 16'({rd_w_q, scan_res.idx});
            state_d      = ST_DONE;
          end else if (rd_w_q == win_q.last[AW+4:5]) begin
            if (!seg_sel_q) begin
              seg_sel_d = 1'b1;
              state_d   = ST_SETUP;
            end else begin
              res_status_d = pba_pkg::STATUS_NO_FREE;
              res_port_d   = 16'd0;
              state_d      = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_data_d.status     = res_status_q;
          out_data_d.bound_port = res_port_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      seg_sel_q     <= 1'b0;
      rd_vld_q      <= 1'b0;
      iss_q         <= '0;
      range_start_q <= pba_pkg::RANGE_START_RST;
      range_end_q   <= pba_pkg::RANGE_END_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      seg_sel_q   <= seg_sel_d;
      rd_vld_q    <= rd_vld_d;
      iss_q       <= iss_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pba_pkg::CFG_RANGE_START: range_start_q <= cfg_data_i;
          pba_pkg::CFG_RANGE_END:   range_end_q   <= cfg_data_i;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_port_q   <= res_port_d;
    out_data_q   <= out_data_d;
    win_q        <= win_d;
    rd_w_q       <= rd_w_d;
  end

endmodule

`default_nettype wire
